FILE: src/quad_encoder_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Quadrature decoder assertion macros
// Shared property forms for the decoder's checker. They expect signals named
// clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef QUAD_ENCODER_DECODER_TOP_ASSERT_SVH
`define QUAD_ENCODER_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QED_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/qed_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature decoder package
// Operation codes, register indexes, reset values and stream field layout.
// ----------------------------------------------------------------------------
`default_nettype none

package qed_pkg;

	// Operation carried in the slave tuser field.
	typedef enum logic [1:0] {
		OP_SAMPLE     = 2'd0,
		OP_READ_DELTA = 2'd1,
		OP_READ_POS   = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_BOUNCE_DELAY = 2'd0,
		CFG_FAST_WINDOW  = 2'd1,
		CFG_FAST_GAIN    = 2'd2
	} cfg_idx_t;

	// Register widths and reset values.
	localparam int BOUNCE_W    = 16;
	localparam int WINDOW_W    = 20;
	localparam int GAIN_W      = 4;
	localparam int CFG_DATA_W  = 20;
	localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 16'd2000;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd10000;
	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd3;

	// Input field widths and positions in the slave tdata.
	localparam int OP_W      = 2;
	localparam int PIN_W     = 8;
	localparam int TIME_W    = 32;
	localparam int IDX_W     = 2;
	localparam int PIN_LSB   = 0;
	localparam int TIME_LSB  = PIN_LSB + PIN_W;
	localparam int IDX_LSB   = TIME_LSB + TIME_W;
	localparam int S_DATA_W  = 48;

	// Output field widths and positions in the master tdata.
	localparam int VALUE_W   = 32;
	localparam int VALUE_LSB = 0;
	localparam int FAST_BIT  = VALUE_LSB + VALUE_W;
	localparam int M_DATA_W  = 40;

	// Per-channel control from the top level.
	typedef struct packed {
		logic sample_en;
		logic clear_en;
	} chan_ctrl_t;

endpackage

`default_nettype wire

FILE: src/qed_channel.sv
// ----------------------------------------------------------------------------
// Quadrature decoder channel
// Holds one encoder's phase history, position and last position, and applies
// the A-edge and B-edge rules for an accepted pin sample.
// ----------------------------------------------------------------------------
`default_nettype none

module qed_channel
	import qed_pkg::*;
#(
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire chan_ctrl_t                ctrl,
	input  wire logic                      phase_a,
	input  wire logic                      phase_b,
	output logic [POSITION_WIDTH-1:0]      position,
	output logic [POSITION_WIDTH-1:0]      last_position
);

	localparam logic [POSITION_WIDTH-1:0] STEP_UP   = POSITION_WIDTH'(1);
	localparam logic [POSITION_WIDTH-1:0] STEP_DOWN = '1;

	logic                      prev_a_q;
	logic                      prev_b_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic [POSITION_WIDTH-1:0] last_q;

	logic                      a_chg;
	logic                      b_chg;
	logic [POSITION_WIDTH-1:0] step_a;
	logic [POSITION_WIDTH-1:0] step_b;
	logic [POSITION_WIDTH-1:0] pos_mid;
	logic [POSITION_WIDTH-1:0] pos_new;
	logic [POSITION_WIDTH-1:0] last_new;

	// An A edge counts up when the phases agree afterwards; a B edge when they differ.
	always_comb begin
		a_chg    = phase_a ^ prev_a_q;
		b_chg    = phase_b ^ prev_b_q;
		step_a   = (phase_a == phase_b) ? STEP_UP : STEP_DOWN;
		step_b   = (phase_a != phase_b) ? STEP_UP : STEP_DOWN;
		pos_mid  = a_chg ? (pos_q + step_a) : pos_q;
		pos_new  = b_chg ? (pos_mid + step_b) : pos_mid;
		// The B edge is applied second, so it records the position after the A step.
		if (b_chg) begin
			last_new = pos_mid;
		end else if (a_chg) begin
			last_new = pos_q;
		end else begin
			last_new = last_q;
		end
	end

	// Channel state: updated by a sample, or last position caught up by a delta read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= 1'b0;
			prev_b_q <= 1'b0;
			pos_q    <= '0;
			last_q   <= '0;
		end else if (ctrl.sample_en) begin
			prev_a_q <= phase_a;
			prev_b_q <= phase_b;
			pos_q    <= pos_new;
			last_q   <= last_new;
		end else if (ctrl.clear_en) begin
			last_q   <= pos_q;
		end
	end

	assign position      = pos_q;
	assign last_position = last_q;

endmodule

`default_nettype wire

FILE: src/quad_encoder_decoder_top.sv
// ----------------------------------------------------------------------------
// Quadrature decoder, top level
// Multi-channel quadrature decoder with debounce, fast-turn detection and
// scaled delta reads over a stream interface.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the slave stream; tuser carries the operation (pin sample,
// delta read or position read) and tdata the pin levels, the microsecond
// timestamp and the encoder index. A pin sample updates the channels and
// gives no result. Each read gives one result on the master stream: the
// value in the low 32 bits of tdata and the fast flag above it.
// An item is registered on acceptance in the input register and handled from
// there by a single pass of logic into the output register, where a read's
// result is offered on the master side. One item is accepted every cycle,
// limited only by the output register.
// When the receiver stalls, the output register holds its result and the
// input register holds a following read; new items are refused only then.
// Reset clears all positions, phase history, the sample time and the fast
// flag, and loads the configuration registers with their defaults.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must do so only while idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module quad_encoder_decoder_top
	import qed_pkg::*;
#(
	parameter int NUM_ENCODERS   = 4,
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,   // pin_levels[7:0], sample_time_us[39:8],
	                                              // encoder_index[41:40], zero[47:42]
	input  wire logic [OP_W-1:0]       s_tuser,   // op[1:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_DATA_W-1:0]        m_tdata    // read_value[31:0], fast_flag[32], zero[39:33]
);

	// Configuration registers.
	logic [BOUNCE_W-1:0] bounce_q;
	logic [WINDOW_W-1:0] window_q;
	logic [GAIN_W-1:0]   gain_q;

	// Input stage.
	logic              valid_s1;
	op_t               op_s1;
	logic [PIN_W-1:0]  pins_s1;
	logic [TIME_W-1:0] time_s1;
	logic [IDX_W-1:0]  idx_s1;

	// Shared state.
	logic [TIME_W-1:0] prev_time_q;
	logic              fast_q;

	// Output register.
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_fast_q;

	// Datapath.
	logic                      is_read;
	logic                      advance;
	logic                      sample_take;
	logic                      sample_ok;
	logic [TIME_W-1:0]         elapsed;
	logic                      idx_ok;
	logic [POSITION_WIDTH-1:0] sel_pos;
	logic [POSITION_WIDTH-1:0] sel_last;
	logic [POSITION_WIDTH-1:0] delta_p;
	logic [VALUE_W-1:0]        delta32;
	logic [VALUE_W-1:0]        pos32;
	logic [VALUE_W+GAIN_W-1:0] product;
	logic [VALUE_W-1:0]        read_value;

	logic [POSITION_WIDTH-1:0] chan_pos  [NUM_ENCODERS];
	logic [POSITION_WIDTH-1:0] chan_last [NUM_ENCODERS];
	chan_ctrl_t                chan_ctrl [NUM_ENCODERS];

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounce_q <= BOUNCE_RESET;
			window_q <= WINDOW_RESET;
			gain_q   <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BOUNCE_DELAY: bounce_q <= cfg_wdata[BOUNCE_W-1:0];
				CFG_FAST_WINDOW:  window_q <= cfg_wdata[WINDOW_W-1:0];
				CFG_FAST_GAIN:    gain_q   <= cfg_wdata[GAIN_W-1:0];
				default:          ;
			endcase
		end
	end

	// The input stage moves on unless a read meets a full, stalled output register.
	always_comb begin
		is_read  = (op_s1 == OP_READ_DELTA) || (op_s1 == OP_READ_POS);
		advance  = valid_s1 && (!is_read || !out_valid_q || m_tready);
		s_tready = !valid_s1 || advance;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= op_t'(s_tuser);
			pins_s1 <= s_tdata[PIN_LSB +: PIN_W];
			time_s1 <= s_tdata[TIME_LSB +: TIME_W];
			idx_s1  <= s_tdata[IDX_LSB +: IDX_W];
		end
	end

	// Debounce: a sample counts only when the wrapping elapsed time exceeds the delay.
	always_comb begin
		elapsed     = time_s1 - prev_time_q;
		sample_take = advance && (op_s1 == OP_SAMPLE);
		sample_ok   = sample_take && (elapsed > TIME_W'(bounce_q));
	end

	// Sample time on every sample; fast flag only on a sample that passed debounce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			fast_q      <= 1'b0;
		end else begin
			if (sample_take) begin
				prev_time_q <= time_s1;
			end
			if (sample_ok) begin
				fast_q <= (elapsed < TIME_W'(window_q));
			end
		end
	end

	// Decoder channels; encoders whose pins lie beyond the pin field see low phases.
	for (genvar n = 0; n < NUM_ENCODERS; n++) begin : g_chan
		logic pa;
		logic pb;

		if (2 * n + 1 < PIN_W) begin : g_pins
			assign pa = pins_s1[2*n];
			assign pb = pins_s1[2*n+1];
		end else begin : g_nopins
			assign pa = 1'b0;
			assign pb = 1'b0;
		end

		always_comb begin
			chan_ctrl[n].sample_en = sample_ok;
			chan_ctrl[n].clear_en  = advance && (op_s1 == OP_READ_DELTA) &&
			                         (int'(idx_s1) == n);
		end

		qed_channel #(
			.POSITION_WIDTH(POSITION_WIDTH)
		) u_chan (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (chan_ctrl[n]),
			.phase_a      (pa),
			.phase_b      (pb),
			.position     (chan_pos[n]),
			.last_position(chan_last[n])
		);
	end

	// Channel selection for a read.
	always_comb begin
		idx_ok   = 1'b0;
		sel_pos  = '0;
		sel_last = '0;
		for (int n = 0; n < NUM_ENCODERS; n++) begin
			if (int'(idx_s1) == n) begin
				idx_ok   = 1'b1;
				sel_pos  = chan_pos[n];
				sel_last = chan_last[n];
			end
		end
	end

	// Read value: sign-extended delta, scaled by the gain while fast, or the position; zero for an index with no channel.
	always_comb begin
		delta_p = sel_pos - sel_last;
		delta32 = VALUE_W'(signed'(delta_p));
		pos32   = VALUE_W'(signed'(sel_pos));
		product = (VALUE_W+GAIN_W)'(delta32) * (VALUE_W+GAIN_W)'(gain_q);
		if (!idx_ok) begin
			read_value = '0;
		end else if (op_s1 == OP_READ_DELTA) begin
			read_value = fast_q ? product[VALUE_W-1:0] : delta32;
		end else begin
			read_value = pos32;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_read) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_read) begin
			out_value_q <= read_value;
			out_fast_q  <= fast_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_DATA_W - VALUE_W - 1)'(0), out_fast_q, out_value_q};

endmodule

`default_nettype wire

FILE: src/qed_checker.sv
// ----------------------------------------------------------------------------
// Quadrature decoder port checker
// Watches the top level's stream ports for handshake and timing slips, and is
// bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quad_encoder_decoder_top_assert.svh"

module qed_checker
	import qed_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [OP_W-1:0]     s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata
);

	// A stalled result stays offered and unchanged.
	`QED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed or was dropped")

	// Input is refused only while a result waits on a stalled receiver.
	`QED_ASSERT_SAME(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready, "input refused without output backpressure")

	// A fresh result follows a read transfer, by way of the input register and then the output register.
	`QED_ASSERT_SAME(a_result_from_read, $rose(m_tvalid), $past(s_tvalid && s_tready && (s_tuser == OP_READ_DELTA || s_tuser == OP_READ_POS), 2), "result without a matching read transfer")

endmodule

bind quad_encoder_decoder_top qed_checker u_qed_checker (.*);

`default_nettype wire

FILE: bench/quad_encoder_decoder_top_test.sv
// ----------------------------------------------------------------------------
// Quadrature decoder stream testbench
// Feeds pin samples, delta reads and position reads into the decoder through
// its slave stream, predicts every read result from a behavioural copy of the
// four channels, and compares each master-side transfer with the oldest
// prediction. The sender works in random bursts and the receiver stalls on a
// rotating pattern. Configuration changes between phases, with the block idle.
// ----------------------------------------------------------------------------
module quad_encoder_decoder_top_test
	import qed_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENCODERS = 4;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_GUARD = 8;
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 188;

	// One item on the slave stream, and one reading on the master stream.
	typedef struct {
		logic [1:0]  op;
		logic [7:0]  pins;
		logic [31:0] stamp;
		logic [1:0]  enc;
	} enc_item_t;

	typedef struct {
		logic [31:0] value;
		logic        fast;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_BOUNCE_DELAY;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // pin_levels, sample_time_us, encoder_index, zero
	logic [OP_W-1:0] s_tuser = OP_SAMPLE; // op
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [M_DATA_W-1:0] m_tdata;        // read_value, fast_flag, zero

	quad_encoder_decoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	// Items waiting to be sent, and readings waiting to arrive.
	enc_item_t queued_items[$];
	reading_t awaited_readings[$];
	int unsigned n_issued = 0;
	int unsigned n_taken = 0;
	int unsigned n_mismatch = 0;

	// Behavioural copy of the decoder state and its configuration.
	logic [31:0] pos [ENCODERS];
	logic [31:0] last_pos [ENCODERS];
	logic prev_a [ENCODERS];
	logic prev_b [ENCODERS];
	logic [31:0] prev_stamp;
	logic fast_now;
	logic [BOUNCE_W-1:0] bounce_cfg;
	logic [WINDOW_W-1:0] window_cfg;
	logic [GAIN_W-1:0] gain_cfg;

	// Stimulus side: the phase each encoder is driven through, and the last stamp.
	logic [1:0] drive_phase [ENCODERS];
	logic [31:0] stamp_gen;

	// Count of one quadrature edge: +1 or -1 modulo 2^32, or nothing.
	function automatic logic [31:0] quad_step(input logic a, input logic pa,
			input logic b, input logic pb);
		if (!pa && a)
			return b ? 32'd1 : 32'hFFFF_FFFF;
		if (pa && !a)
			return b ? 32'hFFFF_FFFF : 32'd1;
		if (!pb && b)
			return a ? 32'hFFFF_FFFF : 32'd1;
		if (pb && !b)
			return a ? 32'd1 : 32'hFFFF_FFFF;
		return 32'd0;
	endfunction

	// Apply one accepted item to the channel copy; reads leave a prediction.
	function automatic void decode_step(input enc_item_t it);
		logic [31:0] elapsed;
		logic [31:0] delta;
		logic a;
		logic b;
		int n;
		reading_t rd;
		case (it.op)
			OP_SAMPLE: begin
				elapsed = it.stamp - prev_stamp;
				if (elapsed > {16'd0, bounce_cfg}) begin
					for (n = 0; n < ENCODERS; n++) begin
						a = it.pins[2*n];
						b = it.pins[2*n+1];
						if (a != prev_a[n]) begin
							last_pos[n] = pos[n];
							pos[n] = pos[n] + quad_step(a, prev_a[n], b, prev_b[n]);
							prev_a[n] = a;
						end
						if (b != prev_b[n]) begin
							last_pos[n] = pos[n];
							pos[n] = pos[n] + quad_step(a, prev_a[n], b, prev_b[n]);
							prev_b[n] = b;
						end
					end
					fast_now = elapsed < {12'd0, window_cfg};
				end
				prev_stamp = it.stamp;
			end
			OP_READ_DELTA: begin
				delta = pos[it.enc] - last_pos[it.enc];
				last_pos[it.enc] = pos[it.enc];
				rd.value = fast_now ? delta * {28'd0, gain_cfg} : delta;
				rd.fast = fast_now;
				awaited_readings.push_back(rd);
			end
			OP_READ_POS: begin
				rd.value = pos[it.enc];
				rd.fast = fast_now;
				awaited_readings.push_back(rd);
			end
			default: begin
			end
		endcase
	endfunction

	// Sender: random bursts with random gaps; an offered item is held until taken.
	enc_item_t bus_item;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				decode_step(bus_item);
				n_taken++;
			end
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (queued_items.size() != 0) begin
				bus_item = queued_items.pop_front();
				s_tdata <= {6'd0, bus_item.enc, bus_item.stamp, bus_item.pins};
				s_tuser <= bus_item.op;
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: a 16-bit ready pattern rotated every cycle, renewed when a 6-bit age counter wraps.
	logic [15:0] ready_pat = 16'hFFFF;
	logic [5:0] pat_age = '0;

	always @(posedge clk) begin
		pat_age <= pat_age + 6'd1;
		if (pat_age == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pat <= 16'hFFFF;
				1: ready_pat <= 16'h0001;
				default: ready_pat <= 16'($urandom()) | 16'h0001;
			endcase
			m_tready <= 1'b1;
		end else begin
			ready_pat <= {ready_pat[0], ready_pat[15:1]};
			m_tready <= ready_pat[0];
		end
	end

	// Monitor: each transfer on the master side against the oldest prediction.
	reading_t want;
	logic [31:0] got_value;
	logic got_fast;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_value = m_tdata[VALUE_LSB +: VALUE_W];
			got_fast = m_tdata[FAST_BIT];
			if (awaited_readings.size() == 0) begin
				$display("%t: unexpected reading: expected none, actual value %h fast %b",
					$time, got_value, got_fast);
				n_mismatch++;
			end else begin
				want = awaited_readings.pop_front();
				if (got_value !== want.value) begin
					$display("%t: read_value mismatch: expected %h, actual %h",
						$time, want.value, got_value);
					n_mismatch++;
				end
				if (got_fast !== want.fast) begin
					$display("%t: fast_flag mismatch: expected %b, actual %b",
						$time, want.fast, got_fast);
					n_mismatch++;
				end
			end
		end
	end

	// Watchdog: a long run of cycles without any transfer means the block hung
	// or a reading never came. The longest correct quiet spell is a phase pause.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [7:0] pins,
			input logic [31:0] stamp, input logic [1:0] enc);
		enc_item_t it;
		it.op = op;
		it.pins = pins;
		it.stamp = stamp;
		it.enc = enc;
		queued_items.push_back(it);
		n_issued++;
	endtask

	// Wait until every item is taken and every reading has arrived, then let
	// any sample still in the pipeline settle.
	task automatic wait_idle();
		while (n_taken != n_issued || awaited_readings.size() != 0)
			@(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
			CFG_BOUNCE_DELAY: bounce_cfg = v[BOUNCE_W-1:0];
			CFG_FAST_WINDOW: window_cfg = v[WINDOW_W-1:0];
			CFG_FAST_GAIN: gain_cfg = v[GAIN_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(input logic [CFG_DATA_W-1:0] bounce,
			input logic [CFG_DATA_W-1:0] window, input logic [CFG_DATA_W-1:0] gain);
		set_reg(CFG_BOUNCE_DELAY, bounce);
		set_reg(CFG_FAST_WINDOW, window);
		set_reg(CFG_FAST_GAIN, gain);
	endtask

	// Mostly clean quadrature walks with spacing around the bounce and fast
	// limits, mixed with reads, raw pin noise, stray timestamps and unused ops.
	task automatic run_random(input int count);
		int k;
		int n;
		int unsigned span;
		int unsigned bounce;
		int unsigned window;
		logic [7:0] pins;
		int unsigned pick;
		bounce = 32'(bounce_cfg);
		window = 32'(window_cfg);
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if ($urandom_range(0, 9) == 0) begin
					pins = 8'($urandom());
				end else begin
					for (n = 0; n < ENCODERS; n++) begin
						case ($urandom_range(0, 9))
							0, 1, 2, 3: drive_phase[n] = drive_phase[n] + 2'd1;
							4, 5: drive_phase[n] = drive_phase[n] - 2'd1;
							6: drive_phase[n] = drive_phase[n] + 2'd2;
							default: begin
							end
						endcase
						pins[2*n +: 2] = drive_phase[n] ^ (drive_phase[n] >> 1);
					end
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: span = bounce + 1 + $urandom_range(0, window);
					5: span = window;
					6: span = (window == 0) ? 0 : window - 1;
					7: span = $urandom_range(0, bounce);
					8: span = $urandom();
					default: span = bounce + 1;
				endcase
				stamp_gen = stamp_gen + span;
				push_item(OP_SAMPLE, pins, stamp_gen, 2'($urandom()));
			end else if (pick < 75) begin
				push_item(OP_READ_DELTA, 8'($urandom()), $urandom(), 2'($urandom()));
			end else if (pick < 95) begin
				push_item(OP_READ_POS, 8'($urandom()), $urandom(), 2'($urandom()));
			end else begin
				push_item(OP_UNUSED, 8'($urandom()), $urandom(), 2'($urandom()));
			end
		end
	endtask

	initial begin
		for (int n = 0; n < ENCODERS; n++) begin
			pos[n] = '0;
			last_pos[n] = '0;
			prev_a[n] = 1'b0;
			prev_b[n] = 1'b0;
			drive_phase[n] = '0;
		end
		prev_stamp = '0;
		fast_now = 1'b0;
		bounce_cfg = BOUNCE_RESET;
		window_cfg = WINDOW_RESET;
		gain_cfg = GAIN_RESET;

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reads of the cleared state, a sample exactly at the bounce
		// limit, a downward wrap of position, a fast delta with gain, the
		// timestamp wrapping round, a sample exactly at the fast window, both
		// phases changing at once, and an unused op.
		push_item(OP_READ_POS, 8'h00, 32'h0000_0000, 2'd0);
		push_item(OP_READ_DELTA, 8'hFF, 32'hFFFF_FFFF, 2'd3);
		push_item(OP_SAMPLE, 8'h00, 32'd2000, 2'd0);
		push_item(OP_SAMPLE, 8'h55, 32'd4001, 2'd0);
		push_item(OP_READ_DELTA, 8'h00, 32'd0, 2'd0);
		push_item(OP_READ_POS, 8'h00, 32'd0, 2'd0);
		push_item(OP_SAMPLE, 8'hFF, 32'd4002, 2'd0);
		push_item(OP_SAMPLE, 8'hFF, 32'd20000, 2'd0);
		push_item(OP_READ_DELTA, 8'h00, 32'd0, 2'd1);
		push_item(OP_SAMPLE, 8'hAA, 32'h0000_1000, 2'd0);
		push_item(OP_READ_POS, 8'h00, 32'd0, 2'd1);
		push_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 2'd3);
		push_item(OP_SAMPLE, 8'h00, 32'h0000_1000 + 32'd2001, 2'd0);
		push_item(OP_SAMPLE, 8'h33, 32'h0000_1000 + 32'd12001, 2'd0);
		push_item(OP_SAMPLE, 8'hCC, 32'h0000_1000 + 32'd14002, 2'd0);
		for (int n = 0; n < ENCODERS; n++)
			push_item(OP_READ_DELTA, 8'h00, 32'd0, 2'(n));
		for (int n = 0; n < ENCODERS; n++)
			push_item(OP_READ_POS, 8'h00, 32'd0, 2'(n));
		push_item(OP_SAMPLE, 8'h00, 32'hFFFF_FFFF, 2'd0);
		push_item(OP_READ_DELTA, 8'h00, 32'd0, 2'd2);
		stamp_gen = 32'hFFFF_FFFF;

		// Random phases under a series of settings, extremes first.
		run_random(PHASE_ITEMS);
		wait_idle();
		set_all(20'd0, 20'hFFFFF, 20'd15);
		run_random(PHASE_ITEMS);
		wait_idle();
		set_all(20'd65535, 20'd0, 20'd1);
		run_random(PHASE_ITEMS);
		wait_idle();
		// A gain of zero lies outside the range but still scales to zero.
		set_all(20'd1, 20'd3000, 20'd0);
		run_random(PHASE_ITEMS);
		for (int p = 0; p < 2; p++) begin
			wait_idle();
			set_all(20'($urandom_range(0, 5000)), 20'($urandom_range(0, 40000)),
				20'($urandom_range(1, 15)));
			run_random(PHASE_ITEMS);
		end
		wait_idle();

		if (n_mismatch == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/qed_pkg.sv
src/qed_channel.sv
src/quad_encoder_decoder_top.sv
src/qed_checker.sv
bench/quad_encoder_decoder_top_test.sv
